FILE: rtl/lpl_pkg.sv
// Shared types, constants and constant tables of the look-ahead peak limiter.
`default_nettype none

package lpl_pkg;

	localparam int SAMPLE_W = 24;
	localparam int RED_W = 15;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 24;

	// Register indexes of the configuration port
	localparam logic [CFG_ADDR_W-1:0] REG_CEILING_DB    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CEILING_GAIN  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_LOOKAHEAD     = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_ATTACK_COEFF  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_COEFF = 3'd4;

	localparam logic [15:0] CEILING_DB_RST    = 16'd0;
	localparam logic [23:0] UNITY_GAIN        = 24'd8388608;
	localparam logic [8:0]  LOOKAHEAD_RST     = 9'd0;
	localparam logic [15:0] ATTACK_RST        = 16'd0;
	localparam logic [15:0] RELEASE_RST       = 16'd65000;

	// dB per log2 unit in Q16, and log2 units per dB in Q24
	localparam logic [18:0] DB_PER_LOG2_Q16 = 19'd394566;
	localparam logic [21:0] LOG2_PER_DB_Q24 = 22'd2786635;

	localparam logic [14:0] RED_MAX = 15'h7FFF;
	localparam int LOG_STEPS = 16;
	localparam int DIV_STEPS = 23;

	typedef logic [15:0][29:0] roots_t;

	typedef struct packed {
		logic       cap_in;
		logic       log_init;
		logic       log_gain;
		logic       log_step;
		logic       req_fin;
		logic       bk_rd;
		logic       bk_chk;
		logic       push;
		logic       fr_rd;
		logic       fr_chk;
		logic       sm1;
		logic       sm2;
		logic       gn_init;
		logic       ex_step;
		logic       gn_fin;
		logic       out_mul;
		logic       rd_fin;
		logic       out_load;
		logic [4:0] step;
	} lpl_cmd_t;

	typedef struct packed {
		logic win_empty;
		logic bk_pop;
		logic fr_pop;
	} lpl_status_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] rem;
		logic [63:0] bm;
		res = '0;
		rem = v;
		bm = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bm) begin
				rem = rem - (res + bm);
				res = (res >> 1) + bm;
			end else begin
				res = res >> 1;
			end
			bm = bm >> 2;
		end
		return res;
	endfunction

	// Q0.30 roots 2^(-2^-(k+1)), by nested square roots
	function automatic roots_t build_roots();
		roots_t t;
		logic [63:0] r;
		r = isqrt64(64'd1 << 59);
		t[0] = r[29:0];
		for (int k = 1; k < 16; k++) begin
			r = isqrt64(r << 30);
			t[k] = r[29:0];
		end
		return t;
	endfunction

	localparam roots_t EXP_ROOTS = build_roots();

endpackage

`default_nettype wire

FILE: rtl/lpl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lpl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lpl_dp.sv
// Datapath of the limiter: log/exp units, window queue, smoother, divider, delay line.
`default_nettype none

module lpl_dp
	import lpl_pkg::*;
#(
	parameter int MAX_LOOKAHEAD = 511
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic [SAMPLE_W-1:0]   in_sample,
	input  wire lpl_cmd_t              cmd,
	output lpl_status_t                st,
	output logic [39:0]                out_data
);

	localparam int DCAP = MAX_LOOKAHEAD + 1;
	localparam int DW   = $clog2(DCAP);
	localparam int WCAP = MAX_LOOKAHEAD + 2;
	localparam int WW   = $clog2(WCAP);
	localparam int CW   = $clog2(WCAP + 1);
	localparam int LAW  = $clog2(MAX_LOOKAHEAD + 1);
	localparam int WIN_DW = 32 + RED_W;

	// configuration
	logic signed [15:0] ceil_db_q;
	logic [23:0]        ceil_gain_q;
	logic [8:0]         la_cfg_q;
	logic [15:0]        attack_q;
	logic [15:0]        release_q;
	logic [LAW-1:0]     la;

	// item and control state
	logic signed [23:0] x_q;
	logic [23:0]        mag_q;
	logic [WW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic [31:0]        pos_q;
	logic [DW-1:0]      wp_q;
	logic               wrapped_q;
	logic [14:0]        req_q;
	logic [14:0]        wmax_q;
	logic [23:0]        s_q;
	logic [39:0]        p1_q;
	logic [16:0]        cm_q;
	logic signed [23:0] d_q;
	logic [23:0]        dmag_q;
	logic [5:0]         gn_n_q;
	logic [15:0]        gn_fr_q;
	logic [30:0]        gn_m_q;
	logic [24:0]        dv_rem_q;
	logic [22:0]        dv_quo_q;
	logic               clamp_q;
	logic [23:0]        gain_q;
	logic [23:0]        osmp_q;
	logic [14:0]        rd_q;
	logic [39:0]        out_q;

	// log unit
	logic [30:0] lg_mnt_q;
	logic [15:0] lg_f_q;
	logic [4:0]  lg_e_q;
	logic [23:0] lg_src;
	logic [4:0]  lg_e;
	logic [30:0] lg_init_mnt;
	logic [61:0] lg_sq;
	logic [31:0] lg_t;
	logic [20:0] lg_att;
	logic [39:0] lg_prod;
	logic [40:0] lg_sum;
	logic [15:0] lg_db;

	always_comb begin
		lg_e = '0;
		for (int i = 0; i < 24; i++) begin
			if (lg_src[i]) begin
				lg_e = 5'(i);
			end
		end
	end

	assign lg_src = cmd.log_gain ? gain_q : mag_q;
	assign lg_init_mnt = 31'(32'(lg_src) << (5'd30 - lg_e));
	assign lg_sq = lg_mnt_q * lg_mnt_q;
	assign lg_t = lg_sq[61:30];
	assign lg_att = {5'd23 - lg_e_q, 16'h0000} - {5'd0, lg_f_q};
	assign lg_prod = lg_att * DB_PER_LOG2_Q16;
	assign lg_sum = {1'b0, lg_prod} + 41'h800000;
	assign lg_db = lg_sum[39:24];

	// required reduction
	logic signed [17:0] rq;
	assign rq = -18'(ceil_db_q) - $signed({2'b00, lg_db});

	// lookahead, clamped to the capacity
	assign la = (32'(la_cfg_q) > 32'(MAX_LOOKAHEAD)) ? LAW'(MAX_LOOKAHEAD) : LAW'(la_cfg_q);

	// window queue addressing
	logic [CW:0]       wn_sum;
	logic [CW:0]       wn_bsum;
	logic [WW-1:0]     wn_push;
	logic [WW-1:0]     wn_back;
	logic [WW-1:0]     wn_hinc;
	logic [WIN_DW-1:0] wn_rdata;
	logic [14:0]       wn_rval;
	logic [31:0]       wn_rpos;

	assign wn_sum  = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign wn_bsum = wn_sum - (CW+1)'(1);
	assign wn_push = (wn_sum >= (CW+1)'(WCAP)) ? WW'(wn_sum - (CW+1)'(WCAP)) : WW'(wn_sum);
	assign wn_back = (wn_bsum >= (CW+1)'(WCAP)) ? WW'(wn_bsum - (CW+1)'(WCAP)) : WW'(wn_bsum);
	assign wn_hinc = (head_q == WW'(WCAP - 1)) ? '0 : head_q + WW'(1);
	assign wn_rval = wn_rdata[14:0];
	assign wn_rpos = wn_rdata[WIN_DW-1:15];

	assign st.win_empty = (count_q == '0);
	assign st.bk_pop    = (wn_rval <= req_q);
	assign st.fr_pop    = ((pos_q - wn_rpos) > 32'(la));

	lpl_ram #(.WIDTH(WIN_DW), .DEPTH(WCAP)) u_win_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (wn_push),
		.wdata ({pos_q, req_q}),
		.re    (cmd.bk_rd | cmd.fr_rd),
		.raddr (cmd.bk_rd ? wn_back : head_q),
		.rdata (wn_rdata)
	);

	// delay line
	logic [DW:0]   dl_diff;
	logic [DW-1:0] dl_rdidx;
	logic          dl_valid;
	logic [23:0]   dl_rdata;
	logic signed [23:0] dl_d;

	assign dl_diff  = {1'b0, wp_q} - (DW+1)'(la);
	assign dl_rdidx = ({1'b0, wp_q} >= (DW+1)'(la)) ? dl_diff[DW-1:0]
	                                                : DW'(dl_diff + (DW+1)'(DCAP));
	assign dl_valid = wrapped_q || (dl_rdidx <= wp_q);
	assign dl_d     = dl_valid ? $signed(dl_rdata) : 24'sd0;

	lpl_ram #(.WIDTH(SAMPLE_W), .DEPTH(DCAP)) u_dly_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (wp_q),
		.wdata (x_q),
		.re    (cmd.fr_rd),
		.raddr (dl_rdidx),
		.rdata (dl_rdata)
	);

	// smoother
	logic [22:0] sm_t;
	logic [15:0] sm_c;
	logic [39:0] sm_p2;
	logic [40:0] sm_sum;

	assign sm_t   = {wmax_q, 8'h00};
	assign sm_c   = (24'(sm_t) > s_q) ? attack_q : release_q;
	assign sm_p2  = cm_q * sm_t;
	assign sm_sum = {1'b0, p1_q} + {1'b0, sm_p2} + 41'h8000;

	// gain: log2 attenuation, root products, final shift
	logic [45:0] gn_aprod;
	logic [46:0] gn_asum;
	logic [3:0]  gn_k;
	logic [60:0] gn_mp;
	logic [60:0] gn_ms;
	logic [6:0]  gn_sh;
	logic [32:0] gn_rnd;
	logic [23:0] gn_g;
	logic [23:0] gn_cg;

	assign gn_aprod = s_q * LOG2_PER_DB_Q24;
	assign gn_asum  = {1'b0, gn_aprod} + 47'h800000;
	assign gn_k     = cmd.step[3:0];
	assign gn_mp    = gn_m_q * EXP_ROOTS[gn_k];
	assign gn_ms    = gn_mp + 61'h2000_0000;
	assign gn_sh    = 7'd7 + {1'b0, gn_n_q};
	assign gn_rnd   = {2'b00, gn_m_q} + (33'd1 << (gn_sh[4:0] - 5'd1));
	assign gn_g     = (gn_sh > 7'd31) ? '0 : 24'(gn_rnd >> gn_sh[4:0]);
	assign gn_cg    = clamp_q ? {1'b0, dv_quo_q} : UNITY_GAIN;

	// divider step
	logic [24:0] dv_r2;
	assign dv_r2 = {dv_rem_q[23:0], 1'b0};

	// output product
	logic [47:0] op_prod;
	logic [48:0] op_rnd;
	logic [25:0] op_mag;
	assign op_prod = dmag_q * gain_q;
	assign op_rnd  = {1'b0, op_prod} + 49'h400000;
	assign op_mag  = op_rnd[48:23];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceil_db_q   <= CEILING_DB_RST;
			ceil_gain_q <= UNITY_GAIN;
			la_cfg_q    <= LOOKAHEAD_RST;
			attack_q    <= ATTACK_RST;
			release_q   <= RELEASE_RST;
			head_q      <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			s_q         <= '0;
			gain_q      <= UNITY_GAIN;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_CEILING_DB:    ceil_db_q <= cfg_wdata[15:0];
					REG_CEILING_GAIN:  ceil_gain_q <= cfg_wdata[23:0];
					REG_LOOKAHEAD:     la_cfg_q <= cfg_wdata[8:0];
					REG_ATTACK_COEFF:  attack_q <= cfg_wdata[15:0];
					REG_RELEASE_COEFF: release_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			// drop dominated entries from the back
			if (cmd.bk_chk && st.bk_pop) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end
			// drop expired entries from the front
			if (cmd.fr_chk && st.fr_pop) begin
				head_q  <= wn_hinc;
				count_q <= count_q - CW'(1);
			end
			if (cmd.sm1) begin
				pos_q <= pos_q + 32'd1;
				if (wp_q == DW'(MAX_LOOKAHEAD)) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + DW'(1);
				end
			end
			if (cmd.sm2) begin
				s_q <= sm_sum[39:16];
			end
			if (cmd.gn_fin) begin
				gain_q <= (gn_g < gn_cg) ? gn_g : gn_cg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			x_q   <= $signed(in_sample);
			mag_q <= in_sample[23] ? 24'(-$signed(in_sample)) : in_sample;
		end
		if (cmd.log_init) begin
			lg_e_q   <= lg_e;
			lg_mnt_q <= lg_init_mnt;
			lg_f_q   <= '0;
		end
		if (cmd.log_step) begin
			if (lg_t[31]) begin
				lg_mnt_q <= lg_t[31:1];
				lg_f_q   <= {lg_f_q[14:0], 1'b1};
			end else begin
				lg_mnt_q <= lg_t[30:0];
				lg_f_q   <= {lg_f_q[14:0], 1'b0};
			end
		end
		if (cmd.req_fin) begin
			if (mag_q == '0 || rq < 18'sd0) begin
				req_q <= '0;
			end else if (rq > 18'sd32767) begin
				req_q <= RED_MAX;
			end else begin
				req_q <= rq[14:0];
			end
		end
		if (cmd.fr_chk && !st.fr_pop) begin
			wmax_q <= wn_rval;
		end
		if (cmd.sm1) begin
			p1_q   <= sm_c * s_q;
			cm_q   <= 17'h10000 - {1'b0, sm_c};
			d_q    <= dl_d;
			dmag_q <= dl_d[23] ? 24'(-dl_d) : 24'(dl_d);
		end
		if (cmd.gn_init) begin
			gn_n_q   <= gn_asum[45:40];
			gn_fr_q  <= gn_asum[39:24];
			gn_m_q   <= 31'h4000_0000;
			clamp_q  <= dmag_q > ceil_gain_q;
			dv_rem_q <= {1'b0, ceil_gain_q};
			dv_quo_q <= '0;
		end
		if (cmd.ex_step) begin
			if (!cmd.step[4] && gn_fr_q[4'd15 - gn_k]) begin
				gn_m_q <= gn_ms[60:30];
			end
			if (dv_r2 >= {1'b0, dmag_q}) begin
				dv_rem_q <= dv_r2 - {1'b0, dmag_q};
				dv_quo_q <= {dv_quo_q[21:0], 1'b1};
			end else begin
				dv_rem_q <= dv_r2;
				dv_quo_q <= {dv_quo_q[21:0], 1'b0};
			end
		end
		if (cmd.out_mul) begin
			if (d_q < 24'sd0) begin
				osmp_q <= 24'(~op_mag + 26'd1);
			end else if (op_mag > 26'h7FFFFF) begin
				osmp_q <= 24'h7FFFFF;
			end else begin
				osmp_q <= op_mag[23:0];
			end
		end
		if (cmd.rd_fin) begin
			if (gain_q == '0 || lg_db > 16'(RED_MAX)) begin
				rd_q <= RED_MAX;
			end else begin
				rd_q <= lg_db[14:0];
			end
		end
		if (cmd.out_load) begin
			out_q <= {1'b0, rd_q, osmp_q};
		end
	end

	assign out_data = out_q;

	a_front_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fr_rd |-> count_q != '0)
		else $error("window queue empty at front read");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> count_q < CW'(WCAP))
		else $error("window queue overflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sm1 |-> (32'(count_q) <= 32'(la) + 32'd1))
		else $error("window longer than lookahead");

endmodule

`default_nettype wire

FILE: rtl/lpl_ctrl.sv
// Sequencer of the limiter: steps one item through the datapath units.
`default_nettype none

module lpl_ctrl
	import lpl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire lpl_status_t st,
	output lpl_cmd_t         cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_LOG_INIT,
		S_LOG_STEP,
		S_REQ,
		S_BK_TEST,
		S_BK_CHK,
		S_PUSH,
		S_FR_RD,
		S_FR_CHK,
		S_SM1,
		S_SM2,
		S_GN_INIT,
		S_EXP_DIV,
		S_GN_FIN,
		S_RD_INIT,
		S_RD_STEP,
		S_RD_FIN,
		S_DONE
	} state_t;

	state_t     state_q;
	logic [4:0] cnt_q;
	logic       out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.step = cnt_q;
		case (state_q)
			S_IDLE:     cmd.cap_in = in_valid;
			S_LOG_INIT: cmd.log_init = 1'b1;
			S_LOG_STEP: cmd.log_step = 1'b1;
			S_REQ:      cmd.req_fin = 1'b1;
			S_BK_TEST:  cmd.bk_rd = !st.win_empty;
			S_BK_CHK:   cmd.bk_chk = 1'b1;
			S_PUSH:     cmd.push = 1'b1;
			S_FR_RD:    cmd.fr_rd = 1'b1;
			S_FR_CHK:   cmd.fr_chk = 1'b1;
			S_SM1:      cmd.sm1 = 1'b1;
			S_SM2:      cmd.sm2 = 1'b1;
			S_GN_INIT:  cmd.gn_init = 1'b1;
			S_EXP_DIV:  cmd.ex_step = 1'b1;
			S_GN_FIN:   cmd.gn_fin = 1'b1;
			S_RD_INIT: begin
				cmd.log_init = 1'b1;
				cmd.log_gain = 1'b1;
				cmd.out_mul  = 1'b1;
			end
			S_RD_STEP:  cmd.log_step = 1'b1;
			S_RD_FIN: begin
				cmd.rd_fin   = 1'b1;
				cmd.log_gain = 1'b1;
			end
			S_DONE:     cmd.out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_LOG_INIT;
				end
				S_LOG_INIT: begin
					cnt_q   <= '0;
					state_q <= S_LOG_STEP;
				end
				S_LOG_STEP: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(LOG_STEPS - 1)) begin
						state_q <= S_REQ;
					end
				end
				S_REQ:     state_q <= S_BK_TEST;
				S_BK_TEST: state_q <= st.win_empty ? S_PUSH : S_BK_CHK;
				S_BK_CHK:  state_q <= st.bk_pop ? S_BK_TEST : S_PUSH;
				S_PUSH:    state_q <= S_FR_RD;
				S_FR_RD:   state_q <= S_FR_CHK;
				S_FR_CHK:  state_q <= st.fr_pop ? S_FR_RD : S_SM1;
				S_SM1:     state_q <= S_SM2;
				S_SM2:     state_q <= S_GN_INIT;
				S_GN_INIT: begin
					cnt_q   <= '0;
					state_q <= S_EXP_DIV;
				end
				S_EXP_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(DIV_STEPS - 1)) begin
						state_q <= S_GN_FIN;
					end
				end
				S_GN_FIN:  state_q <= S_RD_INIT;
				S_RD_INIT: begin
					cnt_q   <= '0;
					state_q <= S_RD_STEP;
				end
				S_RD_STEP: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(LOG_STEPS - 1)) begin
						state_q <= S_RD_FIN;
					end
				end
				S_RD_FIN:  state_q <= S_DONE;
				S_DONE: if (cmd.out_load) begin
					state_q <= S_IDLE;
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item taken while one is in work");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded result not offered");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !cmd.out_load)
		else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: rtl/lookahead_peak_limiter_unit.sv
// Look-ahead peak limiter: one gain-limited, delayed sample out per sample in.
//
// Input stream s_axis carries one signed Q1.23 sample per item. Output stream
// m_axis carries the delayed sample times the applied gain and the applied
// reduction in Q7.8 dB. Each input item gives exactly one output item.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata:
// 0 ceiling_db, 1 ceiling_gain, 2 lookahead, 3 attack_coeff, 4 release_coeff;
// other indexes are ignored. The user must write them only while the block
// is idle; the block itself does not enforce this.
// One item is in work at a time. The next item is accepted only once the
// current one has been loaded into the output register. Most of each item's
// time goes to the 16-step log2 unit (two passes) and the 23-step divider,
// which runs beside the 16 exp root products.
// A new input item is accepted while the previous result still waits in the
// output register; when the receiver stalls, the finished item holds in the
// sequencer until the output register frees up.
// Reset clears the queue, delay line fill state, smoother and configuration
// registers; the delay line reads as zero until each entry has been written.
`default_nettype none

module lookahead_peak_limiter_unit
	import lpl_pkg::*;
#(
	parameter int MAX_LOOKAHEAD = 511
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [23:0]           s_axis_tdata,  // [23:0] in_sample
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [39:0]                m_axis_tdata,  // [23:0] out_sample, [38:24] reduction_db
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	lpl_cmd_t    cmd;
	lpl_status_t st;

	lpl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.st        (st),
		.cmd       (cmd)
	);

	lpl_dp #(.MAX_LOOKAHEAD(MAX_LOOKAHEAD)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_sample (s_axis_tdata),
		.cmd       (cmd),
		.st        (st),
		.out_data  (m_axis_tdata)
	);

endmodule

`default_nettype wire
